/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define RRTS_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/rrts_pkg.sv */
// ---------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin thread scheduler modules.
// ---------------------------------------------------------------------------
package rrts_pkg;

  localparam int ThreadW       = 4;
  localparam int OpW           = 2;
  localparam int CountW        = 5;
  localparam int DefMaxThreads = 16;

  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_SET_READY = 2'd2,
    OP_SCHEDULE  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Command broadcast from the controller to every queue cell.
  typedef struct packed {
    logic               capture;     // latch per-cell search hit
    logic               shift_all;   // every cell takes its neighbor's entry
    logic               shift_match; // cells at or after the hit take neighbor
    logic               wr_en;       // write wr_data into the addressed cell
    logic [ThreadW-1:0] search_id;
    logic [ThreadW-1:0] wr_data;
  } chain_cmd_t;

endpackage

/* rtl/rrts_cell.sv */
// ---------------------------------------------------------------------------
// rrts_cell
// One ready-queue slot: holds a thread number, flags a search hit and
// passes the shift-enable prefix to the next slot.
// ---------------------------------------------------------------------------
module rrts_cell #(
  parameter int MAX_THREADS = rrts_pkg::DefMaxThreads,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  rrts_pkg::chain_cmd_t               cmd,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   len,
  input  logic [$clog2(MAX_THREADS)-1:0]     wr_idx,
  input  logic [rrts_pkg::ThreadW-1:0]       nbr_entry,
  input  logic                               prefix_in,
  output logic                               prefix_out,
  output logic [rrts_pkg::ThreadW-1:0]       entry,
  output logic                               hit
);

  localparam int IdxW = $clog2(MAX_THREADS);
  localparam int LenW = $clog2(MAX_THREADS + 1);

  logic [rrts_pkg::ThreadW-1:0] entry_r, entry_nxt;
  logic                         hit_r, hit_nxt;
  logic                         shift_here;

  // A slot shifts on removal when the hit lies in it or in any earlier slot.
  assign shift_here = prefix_in | hit_r;
  assign prefix_out = shift_here;

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.capture) begin
      hit_nxt = (entry_r == cmd.search_id) && (LenW'(INDEX) < len);
    end
    entry_nxt = entry_r;
    if (cmd.wr_en && (wr_idx == IdxW'(INDEX))) begin
      entry_nxt = cmd.wr_data;
    end else if (cmd.shift_all || (cmd.shift_match && shift_here)) begin
      entry_nxt = nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

/* rtl/rrts_chain.sv */
// ---------------------------------------------------------------------------
// rrts_chain
// Ready queue built as a row of slots; slot 0 is the queue head.
// ---------------------------------------------------------------------------
module rrts_chain #(
  parameter int MAX_THREADS = rrts_pkg::DefMaxThreads
) (
  input  logic                               clk,
  input  rrts_pkg::chain_cmd_t               cmd,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   len,
  input  logic [$clog2(MAX_THREADS)-1:0]     wr_idx,
  output logic [rrts_pkg::ThreadW-1:0]       head,
  output logic [MAX_THREADS-1:0]             hits
);

  logic [rrts_pkg::ThreadW-1:0] entries [MAX_THREADS];
  logic [MAX_THREADS:0]         prefix;

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    logic [rrts_pkg::ThreadW-1:0] nbr;
    if (i == MAX_THREADS - 1) begin : g_last
      assign nbr = entries[i];
    end else begin : g_mid
      assign nbr = entries[i+1];
    end

    rrts_cell #(
      .MAX_THREADS (MAX_THREADS),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .len        (len),
      .wr_idx     (wr_idx),
      .nbr_entry  (nbr),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .entry      (entries[i]),
      .hit        (hits[i])
    );
  end

  assign head = entries[0];

endmodule

/* rtl/round_robin_thread_scheduler_top.sv */
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Round-robin thread scheduler with a FIFO ready queue and a blocked set.
// ---------------------------------------------------------------------------
// Usage: each input word is one scheduler operation. in_tuser carries the
// operation code (insert, remove, set ready, schedule); in_tdata carries the
// thread number and the blocked flag. Every input word produces exactly one
// output word reporting the running thread, the idle flag, the ready count
// and whether the operation took effect.
// Timing: in the cycle of acceptance every queue slot compares its entry
// against the thread number; in the execute state that follows, the slots
// shift or load as one row and the result is registered. A new word is
// accepted only after the update of the previous word has committed.
// Reset (rst_n low, synchronous) empties the queue and the blocked set and
// makes thread 0 the running thread.
// A stalled receiver is absorbed by the output register: one more word is
// accepted and searched, and its update waits until the held result is
// taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_thread_scheduler_top #(
  parameter int MAX_THREADS = rrts_pkg::DefMaxThreads
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Operation words
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,  // [3:0] thread_id, [4] thread_blocked
  input  logic [rrts_pkg::OpW-1:0]   in_tuser,  // [1:0] operation
  // Result words
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata  // [3:0] running_thread,
                                                // [4] running_is_idle,
                                                // [9:5] ready_count, [10] applied
);

  localparam int IdxW = $clog2(MAX_THREADS);
  localparam int LenW = $clog2(MAX_THREADS + 1);
  localparam int TW   = rrts_pkg::ThreadW;

  rrts_pkg::state_t     state_r, state_nxt;
  rrts_pkg::op_t        op_r, op_nxt;
  logic [TW-1:0]        id_r, id_nxt;
  logic                 flag_r, flag_nxt;

  logic [LenW-1:0]        len_r, len_nxt;
  logic [MAX_THREADS-1:0] blocked_r, blocked_nxt;
  logic [TW-1:0]          cur_r, cur_nxt;
  logic                   idle_r, idle_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_data_r, out_data_nxt;

  rrts_pkg::chain_cmd_t   cmd;
  logic [IdxW-1:0]        wr_idx;
  logic [TW-1:0]          head;
  logic [MAX_THREADS-1:0] hits;

  logic                   accept, apply, applied, exec_st;
  logic                   id_valid, running, is_cur, blk_id, found, len_full, pushed;
  logic [IdxW-1:0]        id_idx, cur_idx;
  logic [LenW-1:0]        eff_len;

  assign in_tready = (state_r == rrts_pkg::ST_IDLE);
  assign exec_st   = (state_r == rrts_pkg::ST_EXEC);
  assign accept    = in_tvalid && in_tready;
  // The update commits only when the output register can take its result.
  assign apply     = exec_st && (!out_valid_r || out_tready);

  // Decode of the held operation against the state at operation start.
  assign id_valid = int'(id_r) < MAX_THREADS;
  assign id_idx   = IdxW'(id_r);
  assign cur_idx  = IdxW'(cur_r);
  assign running  = !idle_r;
  assign is_cur   = running && (cur_r == id_r);
  assign blk_id   = id_valid && blocked_r[id_idx];
  assign found    = |hits;
  assign len_full = (len_r == LenW'(MAX_THREADS));
  assign pushed   = running && !flag_r && !len_full;
  assign eff_len  = len_r + LenW'(pushed);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    flag_nxt      = flag_r;
    len_nxt       = len_r;
    blocked_nxt   = blocked_r;
    cur_nxt       = cur_r;
    idle_nxt      = idle_r;
    applied       = 1'b0;
    wr_idx        = IdxW'(len_r);
    cmd           = '0;
    cmd.capture   = accept;
    cmd.search_id = in_tdata[TW-1:0];
    cmd.wr_data   = id_r;

    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt    = rrts_pkg::op_t'(in_tuser);
          id_nxt    = in_tdata[TW-1:0];
          flag_nxt  = in_tdata[TW];
          state_nxt = rrts_pkg::ST_EXEC;
        end
      end
      rrts_pkg::ST_EXEC: begin
        if (apply) begin
          state_nxt = rrts_pkg::ST_IDLE;
          unique case (op_r)
            rrts_pkg::OP_INSERT: begin
              if (id_valid && !blk_id && !found && !is_cur) begin
                if (flag_r) begin
                  blocked_nxt[id_idx] = 1'b1;
                  applied             = 1'b1;
                end else if (!len_full) begin
                  cmd.wr_en = 1'b1;
                  len_nxt   = len_r + LenW'(1);
                  applied   = 1'b1;
                end
              end
            end
            rrts_pkg::OP_REMOVE: begin
              if (id_valid && found) begin
                cmd.shift_match = 1'b1;
                len_nxt         = len_r - LenW'(1);
                applied         = 1'b1;
              end
              if (blk_id) begin
                blocked_nxt[id_idx] = 1'b0;
                applied             = 1'b1;
              end
              if (is_cur) begin
                idle_nxt = 1'b1;
                applied  = 1'b1;
              end
            end
            rrts_pkg::OP_SET_READY: begin
              if (blk_id && !len_full) begin
                blocked_nxt[id_idx] = 1'b0;
                cmd.wr_en           = 1'b1;
                len_nxt             = len_r + LenW'(1);
                applied             = 1'b1;
              end
            end
            rrts_pkg::OP_SCHEDULE: begin
              applied     = 1'b1;
              cmd.wr_data = cur_r;
              if (running && flag_r && (int'(cur_r) < MAX_THREADS)) begin
                blocked_nxt[cur_idx] = 1'b1;
              end
              if (eff_len != '0) begin
                // With an empty queue the requeued thread is its own successor.
                idle_nxt      = 1'b0;
                cur_nxt       = (len_r == '0) ? cur_r : head;
                cmd.shift_all = 1'b1;
                cmd.wr_en     = pushed && (len_r != '0);
                wr_idx        = IdxW'(len_r - LenW'(1));
                len_nxt       = eff_len - LenW'(1);
              end else begin
                idle_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (apply) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, applied, rrts_pkg::CountW'(len_nxt), idle_nxt,
                       idle_nxt ? TW'(0) : cur_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrts_pkg::ST_IDLE;
      len_r       <= '0;
      blocked_r   <= '0;
      cur_r       <= '0;
      idle_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      blocked_r   <= blocked_nxt;
      cur_r       <= cur_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
  end

  rrts_chain #(
    .MAX_THREADS (MAX_THREADS)
  ) u_chain (
    .clk    (clk),
    .cmd    (cmd),
    .len    (len_r),
    .wr_idx (wr_idx),
    .head   (head),
    .hits   (hits)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // At most one queue slot matches the searched thread, as thread numbers are unique.
  `RRTS_ASSERT(a_len_bound, clk, rst_n, len_r <= LenW'(MAX_THREADS), "ready count overflow")
  `RRTS_ASSERT(a_accept_exec, clk, rst_n, accept |=> exec_st, "no execute after accept")
  `RRTS_ASSERT(a_run_not_blocked, clk, rst_n, !idle_r |-> !blocked_r[cur_idx], "running blocked")
  `RRTS_ASSERT(a_hit_unique, clk, rst_n, exec_st |-> $onehot0(hits), "duplicate queue entry")

endmodule
